/* hdl/morse_text_codec_defines.svh */
// Assertion macros for the Morse text codec.
`ifndef MORSE_TEXT_CODEC_DEFINES_SVH
`define MORSE_TEXT_CODEC_DEFINES_SVH

`ifndef SYNTH
`define MTC_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("morse_text_codec: check failed");
`define MTC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("morse_text_codec: check failed");
`else
`define MTC_ASSERT(label, ante, cons)
`define MTC_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* hdl/mtc_pkg.sv */
// Shared types, constants and symbol tables of the Morse text codec.
package mtc_pkg;

	localparam int MAX_CODE_SYMBOLS_DEF = 6;
	localparam int CODE_BITS = 6;
	localparam int CODE_IDX_W = $clog2(CODE_BITS);
	localparam int LEN_ROM_W = 3;
	localparam int KEY_W = CODE_BITS + 1;
	localparam int ROM_DEPTH = 64;
	localparam int REV_DEPTH = 2 ** KEY_W;

	localparam logic [7:0] ROM_BASE = 8'h20;
	localparam logic [7:0] ROM_TOP = 8'h5F;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] DOT_CHAR = 8'h2E;
	localparam logic [7:0] DASH_CHAR = 8'h2D;
	localparam logic [7:0] LOWER_A = 8'h61;
	localparam logic [7:0] LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;
	localparam logic [7:0] NO_CHAR = 8'h00;

	typedef struct packed {
		logic [LEN_ROM_W-1:0] len;
		logic [CODE_BITS-1:0] pat;
	} sym_entry_t;

	typedef sym_entry_t sym_rom_t [ROM_DEPTH];
	typedef logic [7:0] rev_rom_t [REV_DEPTH];

	typedef enum logic [1:0] {
		JOB_NONE,
		JOB_SPACE,
		JOB_SYMBOLS,
		JOB_CHAR
	} job_kind_t;

	// hit: character in table (encode) or code fit for lookup (decode)
	typedef struct packed {
		job_kind_t kind;
		logic last;
		logic hit;
	} job_t;

	typedef struct packed {
		logic busy;
		logic take;
	} emit_stat_t;

	// {length, pattern}; pattern bit i is symbol i, 1 = dash
	localparam sym_rom_t SYM_ROM = '{
		9'b000_000000, 9'b000_000000, 9'b000_000000, 9'b000_000000,
		9'b000_000000, 9'b000_000000, 9'b000_000000, 9'b110_011110,
		9'b101_001101, 9'b110_101101, 9'b000_000000, 9'b101_001010,
		9'b110_110011, 9'b110_100001, 9'b110_101010, 9'b101_001001,
		9'b101_011111, 9'b101_011110, 9'b101_011100, 9'b101_011000,
		9'b101_010000, 9'b101_000000, 9'b101_000001, 9'b101_000011,
		9'b101_000111, 9'b101_001111, 9'b110_000111, 9'b110_010101,
		9'b000_000000, 9'b101_010001, 9'b000_000000, 9'b110_001100,
		9'b110_010110, 9'b010_000010, 9'b100_000001, 9'b100_000101,
		9'b011_000001, 9'b001_000000, 9'b100_000100, 9'b011_000011,
		9'b100_000000, 9'b010_000000, 9'b100_001110, 9'b011_000101,
		9'b100_000010, 9'b010_000011, 9'b010_000001, 9'b011_000111,
		9'b100_000110, 9'b100_001011, 9'b011_000010, 9'b011_000000,
		9'b001_000001, 9'b011_000100, 9'b100_001000, 9'b011_000110,
		9'b100_001001, 9'b100_001101, 9'b100_000011, 9'b000_000000,
		9'b000_000000, 9'b000_000000, 9'b000_000000, 9'b110_101100
	};

	// Marker bit above the last symbol makes length and pattern one index
	function automatic logic [KEY_W-1:0] code_key(logic [LEN_ROM_W-1:0] len,
			logic [CODE_BITS-1:0] pat);
		logic [KEY_W-1:0] k;
		k = KEY_W'(1) << len;
		return k | KEY_W'(pat);
	endfunction

	// Reverse table; lowest character wins on a shared code
	function automatic rev_rom_t build_rev();
		rev_rom_t r;
		for (int k = 0; k < REV_DEPTH; k++) begin
			r[k] = NO_CHAR;
		end
		for (int i = ROM_DEPTH - 1; i >= 0; i--) begin
			if (SYM_ROM[i].len != '0) begin
				r[code_key(SYM_ROM[i].len, SYM_ROM[i].pat)] = ROM_BASE + 8'(i);
			end
		end
		return r;
	endfunction

endpackage

/* hdl/mtc_in_if.sv */
// Input item channel: one byte and an end-of-text flag.
interface mtc_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_char;
	logic in_last;
	modport source (output valid, output in_char, output in_last, input ready);
	modport sink (input valid, input in_char, input in_last, output ready);
endinterface

/* hdl/mtc_out_if.sv */
// Result item channel: one byte and a last-of-item flag.
interface mtc_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_char;
	logic out_last;
	modport source (output valid, output out_char, output out_last, input ready);
	modport sink (input valid, input out_char, input out_last, output ready);
endinterface

/* hdl/mtc_cfg_if.sv */
// Configuration write channel for the direction register.
interface mtc_cfg_if;
	logic valid;
	logic ready;
	logic to_morse;
	modport source (output valid, output to_morse, input ready);
	modport sink (input valid, input to_morse, output ready);
endinterface

/* hdl/mtc_rom.sv */
// Forward and reverse symbol ROMs with registered read data.
module mtc_rom import mtc_pkg::*; (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [5:0]           fwd_addr,
	input  logic [KEY_W-1:0]     rev_key,
	output sym_entry_t           fwd_data,
	output logic [7:0]           rev_data
);

	localparam sym_rom_t FWD_MEM = SYM_ROM;
	localparam rev_rom_t REV_MEM = build_rev();

	sym_entry_t fwd_q;
	logic [7:0] rev_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_q <= FWD_MEM[fwd_addr];
			rev_q <= REV_MEM[rev_key];
		end
	end

	assign fwd_data = fwd_q;
	assign rev_data = rev_q;

endmodule

/* hdl/mtc_front.sv */
// Item front end: case folding, ROM addressing and the decode code register.
module mtc_front import mtc_pkg::*; #(
	parameter int MAX_CODE_SYMBOLS = MAX_CODE_SYMBOLS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       in_char,
	input  logic             in_last,
	input  logic             to_morse,
	output logic [5:0]       fwd_addr,
	output logic [KEY_W-1:0] rev_key,
	output job_t             job
);

	localparam int LEN_W = $clog2(MAX_CODE_SYMBOLS + 1);

	logic [CODE_BITS-1:0] pat_q, pat_n, key_pat;
	logic [LEN_W-1:0]     len_q, len_n, key_len;
	logic                 inv_q, inv_n;
	logic                 gap_q, gap_n;
	logic [7:0]           ch_u;
	logic                 rom_hit;
	logic [7:0]           rom_off;

	function automatic logic code_ok(logic [LEN_W-1:0] l, logic v);
		return !v && l != '0 && l <= LEN_W'(CODE_BITS);
	endfunction

	assign ch_u = (in_char >= LOWER_A && in_char <= LOWER_Z) ? in_char - CASE_OFFSET : in_char;
	assign rom_hit = ch_u >= ROM_BASE && ch_u <= ROM_TOP;
	assign rom_off = ch_u - ROM_BASE;
	assign fwd_addr = rom_off[5:0];
	assign rev_key = code_key(key_len[LEN_ROM_W-1:0], key_pat);

	always_comb begin
		pat_n = pat_q;
		len_n = len_q;
		inv_n = inv_q;
		gap_n = gap_q;
		key_pat = pat_q;
		key_len = len_q;
		job.kind = JOB_NONE;
		job.last = in_last;
		job.hit = 1'b0;
		if (to_morse) begin
			job.kind = (ch_u == SPACE_CHAR) ? JOB_SPACE : JOB_SYMBOLS;
			job.hit = rom_hit;
		end else if (in_char == SPACE_CHAR) begin
			if (gap_q) begin
				job.kind = JOB_SPACE;
				gap_n = 1'b0;
			end else begin
				job.kind = JOB_CHAR;
				job.hit = code_ok(len_q, inv_q);
				pat_n = '0;
				len_n = '0;
				inv_n = 1'b0;
				gap_n = 1'b1;
			end
		end else begin
			gap_n = 1'b0;
			if (in_char != DOT_CHAR && in_char != DASH_CHAR) begin
				inv_n = 1'b1;
			end else if (len_q >= LEN_W'(MAX_CODE_SYMBOLS)) begin
				inv_n = 1'b1;
			end else begin
				if (in_char == DASH_CHAR && len_q < LEN_W'(CODE_BITS)) begin
					pat_n[len_q[CODE_IDX_W-1:0]] = 1'b1;
				end
				len_n = len_q + LEN_W'(1);
			end
			if (in_last) begin
				job.kind = JOB_CHAR;
				job.hit = code_ok(len_n, inv_n);
				key_pat = pat_n;
				key_len = len_n;
			end
		end
		if (in_last) begin
			pat_n = '0;
			len_n = '0;
			inv_n = 1'b0;
			gap_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			len_q <= '0;
			inv_q <= 1'b0;
			gap_q <= 1'b0;
		end else if (accept) begin
			pat_q <= pat_n;
			len_q <= len_n;
			inv_q <= inv_n;
			gap_q <= gap_n;
		end
	end

endmodule

/* hdl/mtc_emit.sv */
// Result serialiser: expands one job into bytes through the output register.
module mtc_emit import mtc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  job_t       job_in,
	input  sym_entry_t fwd_data,
	input  logic [7:0] rev_data,
	output emit_stat_t stat,
	mtc_out_if.source  out_chan
);

	job_t       job_s1;
	logic       valid_s1;
	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_last_q;

	logic [2:0] sym_len;
	logic [2:0] n_res;
	logic [7:0] res_char;
	logic       can_load, fire, done, at_end;

	assign sym_len = job_s1.hit ? fwd_data.len : 3'd0;

	always_comb begin
		n_res = 3'd0;
		res_char = SPACE_CHAR;
		case (job_s1.kind)
			JOB_SPACE: begin
				n_res = 3'd1;
			end
			JOB_SYMBOLS: begin
				n_res = sym_len + (job_s1.last ? 3'd0 : 3'd1);
				if (idx_q < sym_len) begin
					res_char = fwd_data.pat[idx_q] ? DASH_CHAR : DOT_CHAR;
				end
			end
			JOB_CHAR: begin
				n_res = (job_s1.hit && rev_data != NO_CHAR) ? 3'd1 : 3'd0;
				res_char = rev_data;
			end
			default: begin
				n_res = 3'd0;
			end
		endcase
	end

	assign can_load = !out_valid_q || out_chan.ready;
	assign at_end = idx_q == n_res - 3'd1;
	assign fire = valid_s1 && n_res != 3'd0 && can_load;
	assign done = valid_s1 && (n_res == 3'd0 || (can_load && at_end));

	assign stat.busy = valid_s1;
	assign stat.take = !valid_s1 || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (done) begin
				idx_q <= 3'd0;
			end else if (fire) begin
				idx_q <= idx_q + 3'd1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_chan.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job_in;
		end
		if (fire) begin
			out_char_q <= res_char;
			out_last_q <= at_end;
		end
	end

	assign out_chan.valid = out_valid_q;
	assign out_chan.out_char = out_char_q;
	assign out_chan.out_last = out_last_q;

endmodule

/* hdl/morse_text_codec.sv */
// Morse text codec top level: direction register, front end, ROMs and serialiser.
//
//   channel   role    payload              handshake
//   cfg       sink    to_morse             valid/ready, ready always high
//   in_chan   sink    in_char, in_last     valid/ready
//   out_chan  source  out_char, out_last   valid/ready
//
// An item giving n results, n up to 7, occupies the serialiser until its last byte enters
// the single output register, which takes one byte a cycle while out_chan does not stall.
// ROM reads land in the cycle after the item is taken; the next item is taken in the
// cycle its predecessor's last byte enters the output register.
// Reset clears control state and sets encode mode; the ROMs need no clearing pass.
// A stall on out_chan holds the output register and the serialiser.
`include "morse_text_codec_defines.svh"

module morse_text_codec import mtc_pkg::*; #(
	parameter int MAX_CODE_SYMBOLS = MAX_CODE_SYMBOLS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mtc_cfg_if.sink   cfg,
	mtc_in_if.sink    in_chan,
	mtc_out_if.source out_chan
);

	logic             to_morse_q;
	logic             accept;
	logic [5:0]       fwd_addr;
	logic [KEY_W-1:0] rev_key;
	job_t             job;
	sym_entry_t       fwd_data;
	logic [7:0]       rev_data;
	emit_stat_t       stat;

	assign cfg.ready = 1'b1;
	assign in_chan.ready = stat.take;
	assign accept = in_chan.valid && stat.take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			to_morse_q <= 1'b1;
		end else if (cfg.valid) begin
			to_morse_q <= cfg.to_morse;
		end
	end

	mtc_front #(
		.MAX_CODE_SYMBOLS(MAX_CODE_SYMBOLS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_char  (in_chan.in_char),
		.in_last  (in_chan.in_last),
		.to_morse (to_morse_q),
		.fwd_addr (fwd_addr),
		.rev_key  (rev_key),
		.job      (job)
	);

	mtc_rom u_rom (
		.clk      (clk),
		.rd_en    (accept),
		.fwd_addr (fwd_addr),
		.rev_key  (rev_key),
		.fwd_data (fwd_data),
		.rev_data (rev_data)
	);

	mtc_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.job_in   (job),
		.fwd_data (fwd_data),
		.rev_data (rev_data),
		.stat     (stat),
		.out_chan (out_chan)
	);

	// every result is a symbol, a space or a table character
	`MTC_ASSERT(a_out_range, out_chan.valid, out_chan.out_char >= ROM_BASE && out_chan.out_char <= ROM_TOP)
	`MTC_ASSERT(a_idle_ready, !stat.busy, in_chan.ready)
	`MTC_ASSERT_NXT(a_accept_busy, accept, stat.busy)

endmodule

/* dv/tb_morse_text_codec.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the Morse text codec: directed and random items against a predictor.
module tb_morse_text_codec;
	import mtc_pkg::*;

	localparam int CODE_MAX = MAX_CODE_SYMBOLS_DEF;
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_LIMIT = 60000;

	typedef struct packed {
		logic [7:0] ch;
		logic last;
	} char_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mtc_cfg_if cfg_if();
	mtc_in_if in_if();
	mtc_out_if out_if();

	morse_text_codec u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.in_chan(in_if),
		.out_chan(out_if)
	);

	char_item_t tx_chars[$];
	char_item_t due_chars[$];

	bit enc_mode = 1'b1;
	logic [CODE_BITS-1:0] rx_pattern = '0;
	logic [2:0] rx_len = '0;
	bit rx_bad = 1'b0;
	bit rx_gap = 1'b0;

	bit idle_on = 1'b1;
	bit in_fire = 1'b0;
	int in_gap = 0;
	int out_gap = 0;
	int cfg_writes = 0;
	int err_count = 0;

	always #5 clk = ~clk;

	function automatic string morse_of(logic [7:0] c);
		case (c)
			8'h27: return ".----.";
			8'h28: return "-.--.";
			8'h29: return "-.--.-";
			8'h2B: return ".-.-.";
			8'h2C: return "--..--";
			8'h2D: return "-....-";
			8'h2E: return ".-.-.-";
			8'h2F: return "-..-.";
			"0": return "-----";
			"1": return ".----";
			"2": return "..---";
			"3": return "...--";
			"4": return "....-";
			"5": return ".....";
			"6": return "-....";
			"7": return "--...";
			"8": return "---..";
			"9": return "----.";
			8'h3A: return "---...";
			8'h3B: return "-.-.-.";
			8'h3D: return "-...-";
			8'h3F: return "..--..";
			8'h40: return ".--.-.";
			"A": return ".-";
			"B": return "-...";
			"C": return "-.-.";
			"D": return "-..";
			"E": return ".";
			"F": return "..-.";
			"G": return "--.";
			"H": return "....";
			"I": return "..";
			"J": return ".---";
			"K": return "-.-";
			"L": return ".-..";
			"M": return "--";
			"N": return "-.";
			"O": return "---";
			"P": return ".--.";
			"Q": return "--.-";
			"R": return ".-.";
			"S": return "...";
			"T": return "-";
			"U": return "..-";
			"V": return "...-";
			"W": return ".--";
			"X": return "-..-";
			"Y": return "-.--";
			"Z": return "--..";
			8'h5F: return "..--.-";
			default: return "";
		endcase
	endfunction

	function automatic logic [CODE_BITS-1:0] pattern_of(string s);
		logic [CODE_BITS-1:0] p;
		p = '0;
		for (int i = 0; i < s.len() && i < CODE_BITS; i++) begin
			if (s[i] == DASH_CHAR) begin
				p[i] = 1'b1;
			end
		end
		return p;
	endfunction

	// reverse lookup, lowest character wins
	function automatic bit decode_code(output logic [7:0] hit);
		string s;
		hit = NO_CHAR;
		if (rx_bad || rx_len == 0) begin
			return 1'b0;
		end
		for (int c = 'h20; c <= 'h5F; c++) begin
			s = morse_of(8'(c));
			if (s.len() == int'(rx_len) && pattern_of(s) == rx_pattern) begin
				hit = 8'(c);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void expect_char(logic [7:0] c);
		due_chars.push_back({c, 1'b0});
	endfunction

	function automatic void clear_code();
		rx_pattern = '0;
		rx_len = '0;
		rx_bad = 1'b0;
	endfunction

	function automatic void predict_output(logic [7:0] c_in, logic lst);
		logic [7:0] c;
		logic [7:0] hit;
		string s;
		int n0;
		n0 = due_chars.size();
		c = c_in;
		if (enc_mode) begin
			if (c >= LOWER_A && c <= LOWER_Z) begin
				c = c - CASE_OFFSET;
			end
			if (c == SPACE_CHAR) begin
				expect_char(SPACE_CHAR);
			end else begin
				s = morse_of(c);
				for (int i = 0; i < s.len(); i++) begin
					expect_char((s[i] == DASH_CHAR) ? DASH_CHAR : DOT_CHAR);
				end
				if (!lst) begin
					expect_char(SPACE_CHAR);
				end
			end
		end else if (c == SPACE_CHAR) begin
			if (rx_gap) begin
				expect_char(SPACE_CHAR);
				rx_gap = 1'b0;
			end else begin
				if (decode_code(hit)) begin
					expect_char(hit);
				end
				clear_code();
				rx_gap = 1'b1;
			end
		end else begin
			rx_gap = 1'b0;
			if (c != DOT_CHAR && c != DASH_CHAR) begin
				rx_bad = 1'b1;
			end else if (rx_len >= CODE_MAX) begin
				rx_bad = 1'b1;
			end else begin
				if (c == DASH_CHAR) begin
					rx_pattern[rx_len] = 1'b1;
				end
				rx_len = rx_len + 3'd1;
			end
			if (lst && decode_code(hit)) begin
				expect_char(hit);
			end
		end
		if (lst) begin
			clear_code();
			rx_gap = 1'b0;
		end
		if (due_chars.size() > n0) begin
			due_chars[due_chars.size() - 1].last = 1'b1;
		end
	endfunction

	function automatic void send(logic [7:0] c, logic l);
		tx_chars.push_back({c, l});
	endfunction

	function automatic void random_text(int n);
		logic [7:0] c;
		repeat (n) begin
			case ($urandom_range(0, 9))
				0, 1: c = 8'($urandom_range("A", "Z"));
				2, 3: c = 8'($urandom_range("a", "z"));
				4: c = 8'($urandom_range("0", "9"));
				5: c = SPACE_CHAR;
				6, 7: c = 8'($urandom_range('h20, 'h5F));
				default: c = 8'($urandom_range(0, 255));
			endcase
			send(c, $urandom_range(0, 9) == 0);
		end
	endfunction

	// mostly well-formed codes with random terminators, plus noise
	function automatic void random_morse(int n);
		logic [7:0] c;
		string s;
		int sent;
		int k;
		sent = 0;
		while (sent < n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: begin
					do begin
						c = 8'($urandom_range('h21, 'h5F));
						s = morse_of(c);
					end while (s.len() == 0);
					for (int i = 0; i < s.len(); i++) begin
						send(s[i], 1'b0);
					end
					sent += s.len();
					k = $urandom_range(0, 9);
					if (k == 9) begin
						tx_chars[tx_chars.size() - 1].last = 1'b1;
					end else begin
						send(SPACE_CHAR, k == 8);
						sent++;
						if (k >= 6 && k < 8) begin
							send(SPACE_CHAR, 1'b0);
							sent++;
						end
					end
				end
				7: begin
					k = $urandom_range(CODE_MAX + 1, CODE_MAX + 3);
					repeat (k) begin
						send($urandom_range(0, 1) ? DASH_CHAR : DOT_CHAR, 1'b0);
					end
					send(SPACE_CHAR, $urandom_range(0, 1) == 1);
					sent += k + 1;
				end
				8: begin
					send(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
					sent++;
				end
				default: begin
					k = $urandom_range(1, 4);
					repeat (k) begin
						send(SPACE_CHAR, 1'b0);
					end
					sent += k;
				end
			endcase
		end
	endfunction

	task automatic settle();
		int waited;
		waited = 0;
		while ((tx_chars.size() != 0 || in_if.valid || due_chars.size() != 0)
				&& waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (due_chars.size() != 0) begin
			$error("out_char: expected %0d more items, got none", due_chars.size());
			err_count++;
			due_chars.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_direction(bit enc);
		int seen;
		seen = cfg_writes;
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.to_morse <= enc;
		while (cfg_writes == seen) begin
			@(negedge clk);
		end
		cfg_if.valid <= 1'b0;
	endtask

	// input driver
	always @(negedge clk) begin : drv
		char_item_t nxt;
		if (arst_n) begin
			if (!in_if.valid || in_fire) begin
				if (in_gap != 0) begin
					in_gap <= in_gap - 1;
					in_if.valid <= 1'b0;
				end else if (tx_chars.size() != 0) begin
					nxt = tx_chars.pop_front();
					in_if.valid <= 1'b1;
					in_if.in_char <= nxt.ch;
					in_if.in_last <= nxt.last;
					if (idle_on && $urandom_range(0, 5) == 0) begin
						in_gap <= $urandom_range(1, 10);
					end
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end
	end

	// result sink with stall bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_gap != 0) begin
				out_gap <= out_gap - 1;
				out_if.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_gap <= $urandom_range(0, 9);
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : mon
		char_item_t want;
		if (arst_n) begin
			in_fire <= in_if.valid && in_if.ready;
			if (cfg_if.valid && cfg_if.ready) begin
				enc_mode = cfg_if.to_morse;
				cfg_writes++;
			end
			if (out_if.valid && out_if.ready) begin
				if (due_chars.size() == 0) begin
					$error("out_char: expected none, got %h", out_if.out_char);
					err_count++;
				end else begin
					want = due_chars.pop_front();
					if (out_if.out_char !== want.ch) begin
						$error("out_char: expected %h, got %h", want.ch, out_if.out_char);
						err_count++;
					end
					if (out_if.out_last !== want.last) begin
						$error("out_last: expected %b, got %b", want.last, out_if.out_last);
						err_count++;
					end
				end
			end
			if (in_if.valid && in_if.ready) begin
				predict_output(in_if.in_char, in_if.in_last);
			end
		end
	end

	initial begin
		in_if.valid = 1'b0;
		in_if.in_char = '0;
		in_if.in_last = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.to_morse = 1'b1;
		out_if.ready = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		write_direction(1'b1);
		send("a", 1'b0);
		send("z", 1'b0);
		send(8'h00, 1'b0);
		send(8'hFF, 1'b0);
		send(SPACE_CHAR, 1'b0);
		send("=", 1'b0);
		send("@", 1'b1);
		send("%", 1'b1);
		send(SPACE_CHAR, 1'b1);
		settle();

		write_direction(1'b0);
		// '=' closed by end of message on its final dash
		send(DASH_CHAR, 1'b0);
		send(DOT_CHAR, 1'b0);
		send(DOT_CHAR, 1'b0);
		send(DOT_CHAR, 1'b0);
		send(DASH_CHAR, 1'b1);
		// letter, word space, empty lookup, word space again
		send(DOT_CHAR, 1'b0);
		send(DASH_CHAR, 1'b0);
		repeat (4) send(SPACE_CHAR, 1'b0);
		// stray byte spoils the code
		send(DOT_CHAR, 1'b0);
		send(8'hFF, 1'b1);
		// one symbol too many
		repeat (CODE_MAX + 1) send(DASH_CHAR, 1'b0);
		send(SPACE_CHAR, 1'b1);
		// partial code survives a trip through encode mode
		send(DASH_CHAR, 1'b0);
		send(DASH_CHAR, 1'b0);
		settle();
		write_direction(1'b1);
		send("E", 1'b0);
		settle();
		write_direction(1'b0);
		send(SPACE_CHAR, 1'b0);
		settle();

		random_morse(70);
		settle();
		write_direction(1'b1);
		random_text(40);
		settle();
		write_direction(1'b0);
		random_morse(50);
		settle();
		write_direction(1'b1);
		random_text(30);
		settle();
		idle_on = 1'b0;
		write_direction(1'b0);
		random_morse(40);
		settle();

		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/mtc_pkg.sv
hdl/mtc_in_if.sv
hdl/mtc_out_if.sv
hdl/mtc_cfg_if.sv
hdl/mtc_rom.sv
hdl/mtc_front.sv
hdl/mtc_emit.sv
hdl/morse_text_codec.sv
dv/tb_morse_text_codec.sv
